// ----- rtl/dsd_pkg.sv -----
// shared types, constants and the segment table of the decimal chain driver
// no dependencies
package dsd_pkg;

    localparam int CHAIN_LEN = 9;

    typedef logic [3:0] code_t;
    typedef code_t [CHAIN_LEN-1:0] codes_t;
    typedef logic [3:0] pos_t;
    typedef logic [7:0] seg_t;

    localparam code_t BLANK_CODE  = 4'd10;
    localparam code_t NEVER_SHOWN = 4'd15;
    localparam pos_t  FIRST_POS   = 4'd0;
    localparam pos_t  LAST_POS    = 4'd8;

    // reciprocal constants: floor(x / d) == (x * k) >> s over each value range used
    localparam logic [23:0] K_DIV_100000 = 24'd10995117;   // s = 40, x < 2^23
    localparam logic [10:0] K_DIV_100_L  = 11'd1311;       // s = 17, x < 2^11
    localparam logic [16:0] K_DIV_10000  = 17'd107375;     // s = 30, x < 100000
    localparam logic [17:0] K_DIV_1000   = 18'd134218;     // s = 27, x < 100000
    localparam logic [17:0] K_DIV_100    = 18'd167773;     // s = 24, x < 100000
    localparam logic [16:0] K_DIV_10     = 17'd104858;     // s = 20, x < 100000

    localparam logic [16:0] MASS_WRAP  = 17'd100000;
    localparam logic [10:0] LEN_1000   = 11'd1000;
    localparam logic [10:0] LEN_2000   = 11'd2000;
    localparam logic [6:0]  LEN_100    = 7'd100;

    // register map
    localparam logic REG_SHORT_MODE = 1'b0;

    function automatic seg_t seg_of(input code_t code);
        seg_t seg;
        unique case (code)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h05;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h65;
            4'd5:    seg = 8'h6E;
            4'd6:    seg = 8'h7E;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/dsd_conv.sv -----
// conversion pipeline: clamps the inputs and splits them into nine digit codes
// with leading-zero and hidden-field blanking; depends on dsd_pkg
module dsd_conv
    import dsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [11:0]  length_value,
    input  logic [23:0]  mass_value,
    input  logic         show_length,
    input  logic         show_mass,
    input  logic         short_length_mode,
    output logic         codes_valid,
    input  logic         codes_take,
    output codes_t       codes
);

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    // stage 0: input register
    logic [11:0] len0_reg;
    logic [23:0] mass0_reg;
    logic        sl0_reg, sm0_reg, mode0_reg;

    // stage 1
    logic [22:0] mc1_reg;
    logic [6:0]  mq1_reg;
    logic [10:0] lc1_reg;
    logic [4:0]  lq1_reg;
    logic        sl1_reg, sm1_reg, mode1_reg;

    // stage 2
    logic [16:0] mr2_reg;
    logic [9:0]  lm2_reg;
    logic        sl2_reg, sm2_reg, mode2_reg;

    // stage 3
    logic [16:0] mr3_reg;
    logic [3:0]  q4_3_reg;
    logic [6:0]  q3_3_reg;
    logic [9:0]  q2_3_reg;
    logic [13:0] q1_3_reg;
    logic [9:0]  lm3_reg;
    logic [3:0]  hq3_reg;
    logic [6:0]  tq3_reg;
    logic        sl3_reg, sm3_reg, mode3_reg;

    // stage 4
    codes_t codes4_reg;

    assign rdy4 = !v4_reg || codes_take;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;
    assign in_stall    = !rdy0;
    assign codes_valid = v4_reg;
    assign codes       = codes4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) v0_reg <= in_valid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage 0 -> 1: clamp, mass quotient by 100000, length quotient by 100
    logic [22:0] mc_c;
    logic [10:0] lc_c;
    logic [46:0] mprod_c;
    logic [21:0] lprod_c;

    always_comb
    begin
        mc_c    = mass0_reg[23] ? 23'd0 : mass0_reg[22:0];
        lc_c    = len0_reg[11] ? 11'd0 : len0_reg[10:0];
        mprod_c = 47'(mc_c) * 47'(K_DIV_100000);
        lprod_c = 22'(lc_c) * 22'(K_DIV_100_L);
    end

    // stage 1 -> 2: mass mod 100000, length mod 100 or 1000 by mode
    logic [23:0] msub_c;
    logic [11:0] lsub_c;
    logic [10:0] lm1000_c;
    logic [9:0]  lm_c;

    always_comb
    begin
        msub_c = 24'(mq1_reg) * 24'(MASS_WRAP);
        lsub_c = 12'(lq1_reg) * 12'(LEN_100);
        priority if (lc1_reg >= LEN_2000)
            lm1000_c = lc1_reg - LEN_2000;
        else if (lc1_reg >= LEN_1000)
            lm1000_c = lc1_reg - LEN_1000;
        else
            lm1000_c = lc1_reg;
        if (mode1_reg)
            lm_c = lm1000_c[9:0];
        else
            lm_c = 10'(12'(lc1_reg) - lsub_c);
    end

    // stage 2 -> 3: decimal quotients of the mass and length remainders
    logic [33:0] p4_c;
    logic [34:0] p3_c;
    logic [34:0] p2_c;
    logic [33:0] p1_c;
    logic [27:0] ph_c;
    logic [26:0] pt_c;

    always_comb
    begin
        p4_c = 34'(mr2_reg) * 34'(K_DIV_10000);
        p3_c = 35'(mr2_reg) * 35'(K_DIV_1000);
        p2_c = 35'(mr2_reg) * 35'(K_DIV_100);
        p1_c = 34'(mr2_reg) * 34'(K_DIV_10);
        ph_c = 28'(lm2_reg) * 28'(K_DIV_100);
        pt_c = 27'(lm2_reg) * 27'(K_DIV_10);
    end

    // stage 3 -> 4: digits, blanking
    logic [3:0] d4, d3, d2, d1, d0;
    logic [3:0] lh, lt, lu;
    codes_t     codes_c;

    always_comb
    begin
        d4 = q4_3_reg;
        d3 = 4'(q3_3_reg - 7'(q4_3_reg) * 7'd10);
        d2 = 4'(q2_3_reg - 10'(q3_3_reg) * 10'd10);
        d1 = 4'(q1_3_reg - 14'(q2_3_reg) * 14'd10);
        d0 = 4'(mr3_reg - 17'(q1_3_reg) * 17'd10);
        lh = hq3_reg;
        lt = 4'(tq3_reg - 7'(hq3_reg) * 7'd10);
        lu = 4'(lm3_reg - 10'(tq3_reg) * 10'd10);

        if (!sl3_reg)
        begin
            codes_c[0] = BLANK_CODE;
            codes_c[1] = BLANK_CODE;
            codes_c[2] = BLANK_CODE;
        end
        else if (mode3_reg)
        begin
            codes_c[0] = (lh == 4'd0) ? BLANK_CODE : lh;
            codes_c[1] = (lh == 4'd0 && lt == 4'd0) ? BLANK_CODE : lt;
            codes_c[2] = lu;
        end
        else
        begin
            // scaled by ten: remainder below 100, so the hundreds digit drops out
            codes_c[0] = (lt == 4'd0) ? BLANK_CODE : lt;
            codes_c[1] = lu;
            codes_c[2] = 4'd0;
        end

        if (!sm3_reg)
        begin
            for (int i = 3; i < CHAIN_LEN; i++)
                codes_c[i] = BLANK_CODE;
        end
        else
        begin
            codes_c[3] = (d4 == 4'd0) ? BLANK_CODE : d4;
            codes_c[4] = (d4 == 4'd0 && d3 == 4'd0) ? BLANK_CODE : d3;
            codes_c[5] = (d4 == 4'd0 && d3 == 4'd0 && d2 == 4'd0) ? BLANK_CODE : d2;
            codes_c[6] = (d4 == 4'd0 && d3 == 4'd0 && d2 == 4'd0 && d1 == 4'd0)
                       ? BLANK_CODE : d1;
            codes_c[7] = d0;
            codes_c[8] = 4'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            len0_reg  <= length_value;
            mass0_reg <= mass_value;
            sl0_reg   <= show_length;
            sm0_reg   <= show_mass;
            mode0_reg <= short_length_mode;
        end
        if (rdy1)
        begin
            mc1_reg   <= mc_c;
            mq1_reg   <= mprod_c[46:40];
            lc1_reg   <= lc_c;
            lq1_reg   <= lprod_c[21:17];
            sl1_reg   <= sl0_reg;
            sm1_reg   <= sm0_reg;
            mode1_reg <= mode0_reg;
        end
        if (rdy2)
        begin
            mr2_reg   <= 17'(mc1_reg - 23'(msub_c));
            lm2_reg   <= lm_c;
            sl2_reg   <= sl1_reg;
            sm2_reg   <= sm1_reg;
            mode2_reg <= mode1_reg;
        end
        if (rdy3)
        begin
            mr3_reg   <= mr2_reg;
            q4_3_reg  <= p4_c[33:30];
            q3_3_reg  <= p3_c[33:27];
            q2_3_reg  <= p2_c[33:24];
            q1_3_reg  <= p1_c[33:20];
            lm3_reg   <= lm2_reg;
            hq3_reg   <= ph_c[27:24];
            tq3_reg   <= pt_c[26:20];
            sl3_reg   <= sl2_reg;
            sm3_reg   <= sm2_reg;
            mode3_reg <= mode2_reg;
        end
        if (rdy4)
            codes4_reg <= codes_c;
    end

endmodule

// ----- rtl/dsd_ser.sv -----
// change detection against the last shown pattern and the nine-beat byte serializer
// depends on dsd_pkg
module dsd_ser
    import dsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         codes_valid,
    output logic         codes_take,
    input  codes_t       codes,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   segment_byte,
    output logic [3:0]   digit_position,
    output logic         last_byte
);

    codes_t shown_reg;
    seg_t   seg_reg [CHAIN_LEN];
    pos_t   pos_reg, pos_next;
    logic   busy_reg, busy_next;
    logic   changed, free, load;

    always_comb
    begin
        changed = 1'b0;
        for (int i = 0; i < CHAIN_LEN; i++)
            if (codes[i] != shown_reg[i])
                changed = 1'b1;
    end

    // the next pattern may follow the ninth beat with no gap
    assign free       = !busy_reg || (pos_reg == LAST_POS && !out_stall);
    assign codes_take = !changed || free;
    assign load       = codes_valid && changed && free;

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = FIRST_POS;
        end
        else if (busy_reg && !out_stall)
        begin
            if (pos_reg == LAST_POS)
                busy_next = 1'b0;
            else
                pos_next = pos_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= FIRST_POS;
            for (int i = 0; i < CHAIN_LEN; i++)
                shown_reg[i] <= NEVER_SHOWN;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
            if (load)
                shown_reg <= codes;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            for (int i = 0; i < CHAIN_LEN; i++)
                seg_reg[i] <= seg_of(codes[i]);
    end

    assign out_valid      = busy_reg;
    assign segment_byte   = seg_reg[pos_reg];
    assign digit_position = pos_reg;
    assign last_byte      = (pos_reg == LAST_POS);

endmodule

// ----- rtl/decimal_seven_segment_chain_driver_top.sv -----
// throughput: one input beat per cycle while in_stall is low, into a five-stage conversion
// pipeline; an update that changes the display goes out as nine segment bytes from the
// byte serializer, an unchanged update is taken with no output
// reset: short mode off, pipeline empty, shown pattern set to never shown
// depends on dsd_pkg, dsd_conv and dsd_ser
module decimal_seven_segment_chain_driver_top
    import dsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // config port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input channel
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [11:0]  length_value,
    input  logic [23:0]  mass_value,
    input  logic         show_length,
    input  logic         show_mass,
    // result channel
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   segment_byte,
    output logic [3:0]   digit_position,
    output logic         last_byte
);

    logic   mode_reg;
    logic   codes_valid;
    logic   codes_take;
    codes_t codes;

    // single register at word 0; paddr[2] picks the word, writes elsewhere are dropped
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr[2] == REG_SHORT_MODE)
            mode_reg <= pwdata[0];
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_SHORT_MODE)
            prdata[0] = mode_reg;
    end

    // clamp and decimal split, one stage per multiply level
    dsd_conv u_conv (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .length_value      (length_value),
        .mass_value        (mass_value),
        .show_length       (show_length),
        .show_mass         (show_mass),
        .short_length_mode (mode_reg),
        .codes_valid       (codes_valid),
        .codes_take        (codes_take),
        .codes             (codes)
    );

    // compare against the last shown pattern, then shift out nine beats
    dsd_ser u_ser (
        .clk            (clk),
        .rst_n          (rst_n),
        .codes_valid    (codes_valid),
        .codes_take     (codes_take),
        .codes          (codes),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .segment_byte   (segment_byte),
        .digit_position (digit_position),
        .last_byte      (last_byte)
    );

endmodule
